// ===== design/dtfe_pkg.sv =====
// Shared types, codes and constants for the date/time field editor.
package dtfe_pkg;

  // Event codes carried in the func field
  localparam logic [2:0] FUNC_LOAD_TIME  = 3'd0;
  localparam logic [2:0] FUNC_LOAD_ALARM = 3'd1;
  localparam logic [2:0] FUNC_NEXT       = 3'd2;
  localparam logic [2:0] FUNC_RESET      = 3'd3;
  localparam logic [2:0] FUNC_ADJUST     = 3'd4;

  // Field select codes
  localparam logic [2:0] FLD_CORR    = 3'd0;
  localparam logic [2:0] FLD_YEAR    = 3'd1;
  localparam logic [2:0] FLD_MONTH   = 3'd2;
  localparam logic [2:0] FLD_DAY     = 3'd3;
  localparam logic [2:0] FLD_HOURS   = 3'd4;
  localparam logic [2:0] FLD_MINUTES = 3'd5;

  // Value limits
  localparam logic [11:0]       YEAR_DEFAULT = 12'd2026;
  localparam logic [11:0]       YEAR_LOW     = 12'd2000;
  localparam int                YEAR_SPAN    = 100;
  localparam int                LEAP_CYCLE   = 400;
  localparam int                MONTHS       = 12;
  localparam int                HOURS_MOD    = 24;
  localparam int                MINUTES_MOD  = 60;
  localparam logic signed [8:0] CORR_MAX     = 9'sd99;
  localparam logic signed [8:0] CORR_MIN     = -9'sd99;

  // Modulo reducer sizing: value register, modulus and shift-subtract steps
  localparam int RED_W     = 15;
  localparam int MOD_W     = 9;
  localparam int RED_STEPS = 6;
  localparam int STEP_W    = $clog2(RED_STEPS);

  localparam logic [4:0] MONTH_DAYS [MONTHS] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Input transaction
  typedef struct packed {
    logic [2:0]        func;
    logic signed [3:0] delta;
    logic [11:0]       load_year;
    logic [3:0]        load_month;
    logic [4:0]        load_day;
    logic [4:0]        load_hours;
    logic [5:0]        load_minutes;
    logic signed [7:0] load_correction;
  } btn_t;

  // Result transaction
  typedef struct packed {
    logic              alarm_mode;
    logic [2:0]        field_sel;
    logic [11:0]       year_out;
    logic [3:0]        month_out;
    logic [4:0]        day_out;
    logic [4:0]        hours_out;
    logic [5:0]        minutes_out;
    logic signed [7:0] correction_out;
  } view_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              cap_item;
    logic              decode;
    logic              fix;
    logic              step;
    logic [STEP_W-1:0] step_k;
    logic              write;
    logic              carry;
    logic              clamp;
    logic              capture;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic start_red;
    logic carry_needed;
    logic clamp_needed;
  } status_t;

  // Days in a month; months outside 1..12 count as 31 days
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (month >= 4'd1 && month <= 4'd12) begin
      len = MONTH_DAYS[4'(month - 4'd1)];
      if (month == 4'd2 && leap) begin
        len = 5'd29;
      end
    end
    return len;
  endfunction

endpackage

// ===== design/dtfe_ctrl.sv =====
// Sequencing controller for the date/time field editor.
module dtfe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             btn_valid,
  output logic             btn_ready,
  output logic             view_valid,
  input  logic             view_ready,
  output dtfe_pkg::cmd_t   cmd,
  input  dtfe_pkg::status_t status
);
  import dtfe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FIX,
    S_STEP,
    S_WRITE,
    S_CARRY,
    S_CLAMP,
    S_DONE
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;

  assign btn_ready = (state == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    cmd.step_k    = step_cnt;
    case (state)
      S_IDLE: begin
        if (btn_valid) begin
          cmd.cap_item = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = status.start_red ? S_FIX : S_DONE;
      end
      S_FIX: begin
        cmd.fix       = 1'b1;
        step_cnt_next = STEP_W'(RED_STEPS - 1);
        state_next    = S_STEP;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (step_cnt == '0) begin
          state_next = S_WRITE;
        end else begin
          step_cnt_next = step_cnt - 1'b1;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (status.carry_needed) begin
          state_next = S_CARRY;
        end else if (status.clamp_needed) begin
          state_next = S_CLAMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CARRY: begin
        cmd.carry  = 1'b1;
        state_next = S_FIX;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!view_valid || view_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step_cnt   <= '0;
      view_valid <= 1'b0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
      if (cmd.capture) begin
        view_valid <= 1'b1;
      end else if (view_ready) begin
        view_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/dtfe_datapath.sv =====
// Field registers, modulo reducer and result register of the date/time field editor.
module dtfe_datapath (
  input  logic               clk,
  input  logic               rst,
  input  dtfe_pkg::cmd_t     cmd,
  output dtfe_pkg::status_t  status,
  input  dtfe_pkg::btn_t     btn,
  output dtfe_pkg::view_t    view
);
  import dtfe_pkg::*;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_LEAP,
    TGT_YEAR,
    TGT_MONTH,
    TGT_DAY,
    TGT_HOURS,
    TGT_MINUTES,
    TGT_ALARM_MIN
  } tgt_t;

  // Edit state
  logic              in_alarm_mode;
  logic [2:0]        field_index;
  logic              alarm_min_sel;
  logic [11:0]       year_value;
  logic [3:0]        month_value;
  logic [4:0]        day_value;
  logic [4:0]        hours_value;
  logic [5:0]        minutes_value;
  logic signed [7:0] correction_value;
  logic              leap;

  // Captured transaction and reducer
  btn_t                    item;
  logic signed [RED_W-1:0] red_val;
  logic [MOD_W-1:0]        red_mod;
  tgt_t                    tgt;
  logic                    carry_up;
  logic                    carry_dn;

  tgt_t                    job;
  logic signed [RED_W-1:0] op_val;
  logic [MOD_W-1:0]        op_mod;
  logic signed [RED_W-1:0] dx;
  logic signed [RED_W-1:0] red_cmp;
  logic [MOD_W-1:0]        red_res;
  logic signed [8:0]       corr_sum;
  logic [4:0]              dim;
  logic [4:0]              dim_std;
  logic                    leap_of_res;

  assign dx       = RED_W'(item.delta);
  assign red_cmp  = $signed(RED_W'(red_mod) << cmd.step_k);
  assign red_res  = red_val[MOD_W-1:0];
  assign corr_sum = 9'(correction_value) + 9'(item.delta);
  assign dim      = month_len(month_value, leap);
  assign dim_std  = month_len(month_value, 1'b0);

  // Leap year from the year modulo the 400-year cycle
  assign leap_of_res = (red_res[1:0] == 2'b00) && (red_res != MOD_W'(YEAR_SPAN))
                       && (red_res != MOD_W'(2 * YEAR_SPAN))
                       && (red_res != MOD_W'(3 * YEAR_SPAN));

  // Pick the reduction that the captured transaction needs
  always_comb begin
    job    = TGT_NONE;
    op_val = '0;
    op_mod = '0;
    case (item.func)
      FUNC_LOAD_TIME: job = TGT_LEAP;
      FUNC_ADJUST: begin
        if (in_alarm_mode) begin
          job = alarm_min_sel ? TGT_ALARM_MIN : TGT_HOURS;
        end else begin
          case (field_index)
            FLD_YEAR:    job = TGT_YEAR;
            FLD_MONTH:   job = TGT_MONTH;
            FLD_DAY:     job = TGT_DAY;
            FLD_HOURS:   job = TGT_HOURS;
            FLD_MINUTES: job = TGT_MINUTES;
            default:     job = TGT_NONE;
          endcase
        end
      end
      default: job = TGT_NONE;
    endcase
    case (job)
      TGT_LEAP: begin
        op_val = $signed(RED_W'(item.load_year));
        op_mod = MOD_W'(LEAP_CYCLE);
      end
      TGT_YEAR: begin
        // The 2000 offset is a multiple of the span, so it drops out
        op_val = $signed(RED_W'(year_value)) + dx;
        op_mod = MOD_W'(YEAR_SPAN);
      end
      TGT_MONTH: begin
        op_val = $signed(RED_W'(month_value)) - RED_W'(1) + dx;
        op_mod = MOD_W'(MONTHS);
      end
      TGT_DAY: begin
        op_val = $signed(RED_W'(day_value)) - RED_W'(1) + dx;
        op_mod = MOD_W'(dim);
      end
      TGT_HOURS: begin
        op_val = $signed(RED_W'(hours_value)) + dx;
        op_mod = MOD_W'(HOURS_MOD);
      end
      TGT_MINUTES, TGT_ALARM_MIN: begin
        op_val = $signed(RED_W'(minutes_value)) + dx;
        op_mod = MOD_W'(MINUTES_MOD);
      end
      default: begin
        op_val = '0;
        op_mod = '0;
      end
    endcase
  end

  assign status.start_red    = (job != TGT_NONE);
  assign status.carry_needed = (tgt == TGT_ALARM_MIN) && (carry_up || carry_dn);
  assign status.clamp_needed = (tgt == TGT_YEAR) || (tgt == TGT_MONTH);

  // Edit state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_alarm_mode    <= 1'b0;
      field_index      <= FLD_CORR;
      alarm_min_sel    <= 1'b0;
      year_value       <= YEAR_DEFAULT;
      month_value      <= 4'd1;
      day_value        <= 5'd1;
      hours_value      <= '0;
      minutes_value    <= '0;
      correction_value <= '0;
      leap             <= 1'b0;
      tgt              <= TGT_NONE;
      carry_up         <= 1'b0;
      carry_dn         <= 1'b0;
    end else begin
      // Edits made in the decode state
      if (cmd.decode) begin
        case (item.func)
          FUNC_LOAD_TIME: begin
            in_alarm_mode    <= 1'b0;
            field_index      <= FLD_CORR;
            correction_value <= item.load_correction;
            year_value       <= item.load_year;
            month_value      <= item.load_month;
            day_value        <= item.load_day;
            hours_value      <= item.load_hours;
            minutes_value    <= item.load_minutes;
          end
          FUNC_LOAD_ALARM: begin
            in_alarm_mode <= 1'b1;
            alarm_min_sel <= 1'b0;
            hours_value   <= item.load_hours;
            minutes_value <= item.load_minutes;
          end
          FUNC_NEXT: begin
            if (in_alarm_mode) begin
              alarm_min_sel <= !alarm_min_sel;
            end else if (field_index == FLD_MINUTES) begin
              field_index <= FLD_CORR;
            end else begin
              field_index <= field_index + 3'd1;
            end
          end
          FUNC_RESET: begin
            if (in_alarm_mode) begin
              if (alarm_min_sel) begin
                minutes_value <= '0;
              end else begin
                hours_value <= '0;
              end
            end else begin
              case (field_index)
                FLD_CORR: correction_value <= '0;
                FLD_YEAR: begin
                  // Default year is not a leap year
                  year_value <= YEAR_DEFAULT;
                  leap       <= 1'b0;
                  if (day_value > dim_std) begin
                    day_value <= dim_std;
                  end
                end
                FLD_MONTH:   month_value   <= 4'd1;
                FLD_DAY:     day_value     <= 5'd1;
                FLD_HOURS:   hours_value   <= '0;
                FLD_MINUTES: minutes_value <= '0;
                default:     correction_value <= correction_value;
              endcase
            end
          end
          FUNC_ADJUST: begin
            // Saturate the correction; other fields go through the reducer
            if (!in_alarm_mode && field_index == FLD_CORR) begin
              if (corr_sum > CORR_MAX) begin
                correction_value <= 8'(CORR_MAX);
              end else if (corr_sum < CORR_MIN) begin
                correction_value <= 8'(CORR_MIN);
              end else begin
                correction_value <= 8'(corr_sum);
              end
            end
          end
          default: begin
            field_index <= field_index;
          end
        endcase
        tgt      <= job;
        carry_dn <= (job == TGT_ALARM_MIN) && (op_val < 0);
        carry_up <= (job == TGT_ALARM_MIN) && (op_val >= RED_W'(MINUTES_MOD));
      end

      // Store the reduced value
      if (cmd.write) begin
        case (tgt)
          TGT_LEAP: leap <= leap_of_res;
          TGT_YEAR: begin
            year_value <= YEAR_LOW + 12'(red_res);
            leap       <= (red_res[1:0] == 2'b00);
          end
          TGT_MONTH:                  month_value   <= 4'(red_res) + 4'd1;
          TGT_DAY:                    day_value     <= 5'(red_res) + 5'd1;
          TGT_HOURS:                  hours_value   <= 5'(red_res);
          TGT_MINUTES, TGT_ALARM_MIN: minutes_value <= 6'(red_res);
          default:                    leap          <= leap;
        endcase
      end

      // Carry an alarm minute wrap into hours
      if (cmd.carry) begin
        tgt      <= TGT_HOURS;
        carry_up <= 1'b0;
        carry_dn <= 1'b0;
      end

      // Clamp the day to the month length
      if (cmd.clamp && day_value > dim) begin
        day_value <= dim;
      end
    end
  end

  // Transaction capture and shift-subtract reducer
  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      item <= btn;
    end
    if (cmd.decode) begin
      red_val <= op_val;
      red_mod <= op_mod;
    end else if (cmd.carry) begin
      red_val <= $signed(RED_W'(hours_value)) + (carry_up ? RED_W'(1) : RED_W'(HOURS_MOD - 1));
      red_mod <= MOD_W'(HOURS_MOD);
    end else if (cmd.fix) begin
      if (red_val < 0) begin
        red_val <= red_val + $signed(RED_W'(red_mod));
      end
    end else if (cmd.step) begin
      if (red_val >= red_cmp) begin
        red_val <= red_val - red_cmp;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      view.alarm_mode     <= in_alarm_mode;
      view.field_sel      <= in_alarm_mode ? (alarm_min_sel ? FLD_MINUTES : FLD_HOURS)
                                           : field_index;
      view.year_out       <= year_value;
      view.month_out      <= month_value;
      view.day_out        <= day_value;
      view.hours_out      <= hours_value;
      view.minutes_out    <= minutes_value;
      view.correction_out <= correction_value;
    end
  end

endmodule

// ===== design/date_time_field_editor.sv =====
// Top level of the date/time field editor: controller plus datapath.
//
//   channel  signals                          direction  content
//   btn      btn_valid, btn_ready, btn        in         button event and load values
//   view     view_valid, view_ready, view     out        edited fields after each event
//
// Alarm loads, next, reset, spare codes and correction edits go from decode to the result.
// Time loads (leap year pass) and wrapping edits run a reducer pass, then the day clamp
// after a year or month change, or a second pass when an alarm minute wrap carries into
// hours; each reducer pass is a sign fix step followed by the shift-subtract steps.
// Reset puts every field register at its default.
// A new event is taken only while idle; a result not taken holds the next one back.
module date_time_field_editor (
  input  logic             clk,
  input  logic             rst,
  input  logic             btn_valid,
  output logic             btn_ready,
  input  dtfe_pkg::btn_t   btn,
  output logic             view_valid,
  input  logic             view_ready,
  output dtfe_pkg::view_t  view
);
  import dtfe_pkg::*;

  cmd_t    cmd;
  status_t status;

  dtfe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .btn_valid  (btn_valid),
    .btn_ready  (btn_ready),
    .view_valid (view_valid),
    .view_ready (view_ready),
    .cmd        (cmd),
    .status     (status)
  );

  dtfe_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .btn    (btn),
    .view   (view)
  );

  // Busy after an accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    btn_valid && btn_ready |=> !btn_ready)
    else $error("input accepted again while an event is in progress");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (!view_valid || view_ready))
    else $error("result register overwritten before transfer");

  // Alarm mode shows only hours or minutes as selected
  a_alarm_sel: assert property (@(posedge clk) disable iff (rst)
    view_valid && view.alarm_mode |->
      (view.field_sel == FLD_HOURS || view.field_sel == FLD_MINUTES))
    else $error("alarm mode selects a field other than hours or minutes");

  // Reducer work only happens while an event is in progress
  a_reduce_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.fix || cmd.step || cmd.write) |-> !btn_ready)
    else $error("reducer active while idle");

endmodule
